### src/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg: shared types and constants of the disjoint-set table
// Request and result structs, operation and status codes, and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int unsigned DSU_MAX_ELEMENTS_DEF = 256;
  localparam int unsigned IDX_W                = 8;
  localparam int unsigned TABLE_DEPTH          = 256;

  // operation selector codes
  localparam logic [1:0] OP_MAKE  = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_UNION = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_UNALLOCATED = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] elem_a;
    logic [IDX_W-1:0] elem_b;
  } dsu_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] root_index;
    logic             sets_joined;
    logic [1:0]       status;
  } dsu_out_t;

  // how the pending result is loaded
  typedef enum logic [2:0] {
    RES_KEEP,
    RES_FULL,
    RES_UNALLOC,
    RES_ZERO,
    RES_NEW,
    RES_ROOT
  } res_sel_t;

  typedef struct packed {
    logic     load;      // capture request fields
    logic     make_set;  // write new singleton, bump count
    logic     start_a;   // begin walk at elem_a
    logic     start_b;   // save root of a, begin walk at elem_b
    logic     step;      // fetch grandparent
    logic     halve;     // point node at grandparent, move up
    logic     link;      // link the two roots
    logic     out_load;  // move pending result to output register
    res_sel_t res_sel;
  } dsu_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       a_unalloc;
    logic       b_unalloc;
    logic       at_root;
  } dsu_sts_t;

endpackage

### src/dsu_ram.sv
// ----------------------------------------------------------------------------
// dsu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/dsu_datapath.sv
// ----------------------------------------------------------------------------
// dsu_datapath: parent table, walk registers and result registers
// Executes controller commands against the parent RAM.
// ----------------------------------------------------------------------------
module dsu_datapath import dsu_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  dsu_in_t  in_data,
  input  dsu_cmd_t cmd,
  output dsu_sts_t sts,
  output dsu_out_t out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [1:0]       func_r;
  logic [IDX_W-1:0] a_r;
  logic [IDX_W-1:0] b_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    node_r;
  logic [AW-1:0]    ra_r;
  dsu_out_t         res_r;
  dsu_out_t         res_nxt;
  dsu_out_t         out_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [AW-1:0]    ram_rdata;

  dsu_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_parent_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.func      = func_r;
  assign sts.full      = (count_r == CW'(CAPACITY));
  assign sts.a_unalloc = ({1'b0, a_r} >= (IDX_W + 1)'(count_r));
  assign sts.b_unalloc = ({1'b0, b_r} >= (IDX_W + 1)'(count_r));
  assign sts.at_root   = (ram_rdata == node_r);

  // read address: new walk start, or follow the fetched pointer
  always_comb begin
    priority if (cmd.start_a) begin
      ram_raddr = a_r[AW-1:0];
    end else if (cmd.start_b) begin
      ram_raddr = b_r[AW-1:0];
    end else if (cmd.step || cmd.halve) begin
      ram_raddr = ram_rdata;
    end else begin
      ram_raddr = node_r;
    end
  end

  // writes: new singleton, path halving, or root link
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_r;
    ram_wdata = ram_rdata;
    priority if (cmd.make_set) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = count_r[AW-1:0];
    end else if (cmd.halve) begin
      ram_we    = 1'b1;
      ram_waddr = node_r;
      ram_wdata = ram_rdata;
    end else if (cmd.link) begin
      ram_we    = (ra_r != node_r);
      ram_waddr = (ra_r < node_r) ? node_r : ra_r;
      ram_wdata = (ra_r < node_r) ? ra_r : node_r;
    end else begin
      ram_we = 1'b0;
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.link) begin
      res_nxt.root_index  = IDX_W'((ra_r < node_r) ? ra_r : node_r);
      res_nxt.sets_joined = (ra_r != node_r);
      res_nxt.status      = ST_OK;
    end else begin
      unique case (cmd.res_sel)
        RES_KEEP: begin
          res_nxt = res_r;
        end
        RES_FULL: begin
          res_nxt = '{root_index: '0, sets_joined: 1'b0, status: ST_FULL};
        end
        RES_UNALLOC: begin
          res_nxt = '{root_index: '0, sets_joined: 1'b0, status: ST_UNALLOCATED};
        end
        RES_ZERO: begin
          res_nxt = '{root_index: '0, sets_joined: 1'b0, status: ST_OK};
        end
        RES_NEW: begin
          res_nxt = '{root_index: IDX_W'(count_r[AW-1:0]), sets_joined: 1'b0,
                      status: ST_OK};
        end
        RES_ROOT: begin
          res_nxt = '{root_index: IDX_W'(node_r), sets_joined: 1'b0, status: ST_OK};
        end
        default: begin
          res_nxt = res_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.make_set) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      a_r    <= in_data.elem_a;
      b_r    <= in_data.elem_b;
    end
    if (cmd.start_a) begin
      node_r <= a_r[AW-1:0];
    end else if (cmd.start_b) begin
      node_r <= b_r[AW-1:0];
    end else if (cmd.halve) begin
      node_r <= ram_rdata;
    end
    if (cmd.start_b) begin
      ra_r <= node_r;
    end
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  // parents never point above their own index, so each halving moves up
  a_halve_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.halve |=> (node_r < $past(node_r)))
    else $error("path halving did not move toward the root");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.make_set |-> (count_r < CW'(CAPACITY)))
    else $error("singleton allocated beyond capacity");

  a_parent_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_wdata <= ram_waddr))
    else $error("parent pointer written above its own index");

endmodule

### src/dsu_ctrl.sv
// ----------------------------------------------------------------------------
// dsu_ctrl: operation sequencer
// Decodes the request, runs the root walks and hands off the result.
// ----------------------------------------------------------------------------
module dsu_ctrl import dsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dsu_sts_t sts,
  output dsu_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_HALVE,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   pass_b_r;
  logic   pass_b_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pass_b_nxt    = pass_b_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.res_sel   = RES_KEEP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        pass_b_nxt = 1'b0;
        unique case (sts.func)
          OP_MAKE: begin
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.make_set = 1'b1;
              cmd.res_sel  = RES_NEW;
            end
            state_nxt = S_RESULT;
          end
          OP_FIND: begin
            if (sts.a_unalloc) begin
              cmd.res_sel = RES_UNALLOC;
              state_nxt   = S_RESULT;
            end else begin
              cmd.start_a = 1'b1;
              state_nxt   = S_CHECK;
            end
          end
          OP_UNION: begin
            if (sts.a_unalloc || sts.b_unalloc) begin
              cmd.res_sel = RES_UNALLOC;
              state_nxt   = S_RESULT;
            end else begin
              cmd.start_a = 1'b1;
              state_nxt   = S_CHECK;
            end
          end
          default: begin
            cmd.res_sel = RES_ZERO;
            state_nxt   = S_RESULT;
          end
        endcase
      end
      S_CHECK: begin
        priority if (!sts.at_root) begin
          cmd.step  = 1'b1;
          state_nxt = S_HALVE;
        end else if (sts.func == OP_UNION && !pass_b_r) begin
          cmd.start_b = 1'b1;
          pass_b_nxt  = 1'b1;
        end else if (sts.func == OP_UNION) begin
          cmd.link  = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          cmd.res_sel = RES_ROOT;
          state_nxt   = S_RESULT;
        end
      end
      S_HALVE: begin
        cmd.halve = 1'b1;
        state_nxt = S_CHECK;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_b_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_b_r    <= pass_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwrote an untaken output");

  a_halve_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.halve |-> $past(cmd.step))
    else $error("halve issued without grandparent fetch");

  a_make_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.make_set |-> (!sts.full && sts.func == OP_MAKE))
    else $error("make_set issued on full table or wrong operation");

  a_link_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.link |-> (pass_b_r && sts.func == OP_UNION))
    else $error("link issued before both roots were found");

endmodule

### src/disjoint_set_union_table.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_table: union-find table with path halving
// Each request is taken in S_IDLE, decoded in S_DISPATCH and handed off in
// S_RESULT; find and union walk S_CHECK and S_HALVE for each pointer hop.
// Throughput: one request at a time; the single read port of the parent RAM
// sets the pace of each hop (fetch parent, fetch grandparent).
// Reset: synchronous, active low; clears the allocation count and handshake
// state. Parent entries stay undefined until make_set writes them.
// ----------------------------------------------------------------------------
module disjoint_set_union_table import dsu_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = DSU_MAX_ELEMENTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dsu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dsu_out_t out_data
);

  // Capacity is bounded by the 8-bit index space.
  localparam int unsigned CAPACITY =
    (MAX_ELEMENTS < TABLE_DEPTH) ? MAX_ELEMENTS : TABLE_DEPTH;

  dsu_cmd_t cmd;
  dsu_sts_t sts;

  // Controller: accept a request, decode, sequence the walks, hold the
  // output valid until the result is taken. A new request is accepted
  // while the previous result still waits in the output register.
  dsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: parent RAM, allocation count, walk pointer, saved first root,
  // pending result and the output register.
  dsu_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for disjoint_set_union_table
// Drives make_set, find and union requests through the valid/stall channel,
// predicts every result with a union-find table of its own (path halving,
// smaller root survives) and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dsu_pkg::*;

  // Table capacity: the smaller of the element limit and the index range.
  localparam int unsigned CAPACITY =
    (DSU_MAX_ELEMENTS_DEF < TABLE_DEPTH) ? DSU_MAX_ELEMENTS_DEF : TABLE_DEPTH;
  // Selector value the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 1900;
  localparam int unsigned PAUSE_AT        = 900;
  // Cycles without any handshake before the run is declared hung. The limit
  // leaves a wide margin over a find across the deepest possible chain.
  localparam int unsigned QUIET_LIMIT     = 20000;
  localparam int unsigned SETTLE_CYCLES   = 40;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the parent table, queues the awaited results and
  // compares what comes out of the block.
  // --------------------------------------------------------------------------
  class union_find_scoreboard;
    logic [IDX_W-1:0] parent_of [TABLE_DEPTH];
    int unsigned      sets_given;
    dsu_out_t         awaited_results [$];
    int unsigned      mismatches;
    int unsigned      results_checked;
    int unsigned      n_make, n_full, n_find, n_union, n_joined, n_unalloc, n_unused;
    int unsigned      deepest_walk;

    function new();
      sets_given = 0;
      mismatches = 0;
      results_checked = 0;
      n_make = 0; n_full = 0; n_find = 0; n_union = 0;
      n_joined = 0; n_unalloc = 0; n_unused = 0;
      deepest_walk = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Walk up to the root, pointing every visited entry at its grandparent.
    function logic [IDX_W-1:0] root_with_halving(input logic [IDX_W-1:0] start);
      logic [IDX_W-1:0] node;
      logic [IDX_W-1:0] up;
      int unsigned      hops;
      node = start;
      hops = 0;
      for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
        up = parent_of[node];
        if (up == node) break;
        parent_of[node] = parent_of[up];
        node = parent_of[node];
        hops++;
      end
      if (hops > deepest_walk) deepest_walk = hops;
      return node;
    endfunction

    function void note_request(input dsu_in_t req);
      dsu_out_t         res;
      logic [IDX_W-1:0] ra, rb;
      res = '0;
      case (req.func)
        OP_MAKE: begin
          if (sets_given >= CAPACITY) begin
            res.status = ST_FULL;
            n_full++;
          end else begin
            res.root_index = IDX_W'(sets_given);
            parent_of[IDX_W'(sets_given)] = IDX_W'(sets_given);
            sets_given++;
            n_make++;
          end
        end
        OP_FIND: begin
          if (req.elem_a >= sets_given) begin
            res.status = ST_UNALLOCATED;
            n_unalloc++;
          end else begin
            res.root_index = root_with_halving(req.elem_a);
            n_find++;
          end
        end
        OP_UNION: begin
          if (req.elem_a >= sets_given || req.elem_b >= sets_given) begin
            res.status = ST_UNALLOCATED;
            n_unalloc++;
          end else begin
            ra = root_with_halving(req.elem_a);
            rb = root_with_halving(req.elem_b);
            n_union++;
            if (ra == rb) begin
              res.root_index = ra;
            end else if (ra < rb) begin
              parent_of[rb] = ra;
              res.root_index = ra;
              res.sets_joined = 1'b1;
              n_joined++;
            end else begin
              parent_of[ra] = rb;
              res.root_index = rb;
              res.sets_joined = 1'b1;
              n_joined++;
            end
          end
        end
        default: n_unused++;
      endcase
      awaited_results = {awaited_results, res};
    endfunction

    task check_result(input dsu_out_t got);
      dsu_out_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %p arrived with nothing awaited", got));
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (got.root_index !== want.root_index)
          report_mismatch($sformatf("root_index %0d, expected %0d",
                                    got.root_index, want.root_index));
        if (got.sets_joined !== want.sets_joined)
          report_mismatch($sformatf("sets_joined %0b, expected %0b",
                                    got.sets_joined, want.sets_joined));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    got.status, want.status));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  dsu_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  dsu_out_t out_data;

  always #4 clk = ~clk;

  disjoint_set_union_table #(
    .MAX_ELEMENTS(DSU_MAX_ELEMENTS_DEF)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  union_find_scoreboard sb;

  // Generator state: how many make_set requests have been granted so far, and
  // where the descending chain of unions currently stands.
  int unsigned sets_issued  = 0;
  int unsigned chain_cursor = 0;

  // --------------------------------------------------------------------------
  // Monitors: sample both handshakes at the rising edge. A result can never
  // leave in the cycle its own request enters, so the two blocks may run in
  // either order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: end the run if no request or result moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side back-pressure: switch between no stall, random stall and a
  // fixed duty pattern, each held for a random stretch of cycles.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode  = STALL_NONE;
  int unsigned stall_left  = 0;
  int unsigned stall_phase = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:      out_stall <= ((stall_phase % 7) < 4);
    endcase
  end

  // --------------------------------------------------------------------------
  // Driver: present a request at the falling edge and hold it until taken.
  // --------------------------------------------------------------------------
  task automatic send(input dsu_in_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req.func == OP_MAKE && sets_issued < CAPACITY) sets_issued++;
  endtask

  // Drop valid at the next falling edge and idle for the given cycles.
  task automatic idle(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic dsu_in_t build(input logic [1:0] op, input int unsigned a,
                                    input int unsigned b);
    dsu_in_t req;
    req.func   = op;
    req.elem_a = IDX_W'(a);
    req.elem_b = IDX_W'(b);
    return req;
  endfunction

  // Pick the next random request. Most traffic is well-formed: finds and
  // unions on allocated elements, with a descending run of pairwise unions
  // that builds long parent chains for the finds to halve. The rest is
  // make_set (until and past full), unallocated indices and the unused code.
  function automatic dsu_in_t pick_request();
    dsu_in_t     req;
    int unsigned roll;
    int unsigned bad;
    logic [IDX_W-1:0] swap;
    req  = build(OP_FIND, $urandom_range(0, 255), $urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (sets_issued < 2 || (roll < 20 && sets_issued < CAPACITY) || roll < 3) begin
      req.func = OP_MAKE;
    end else if (roll < 25) begin
      req.func = OP_UNUSED;
    end else if (roll < 33) begin
      // Name an element not yet handed out, on either side of a union.
      req.func = roll[0] ? OP_FIND : OP_UNION;
      if (sets_issued < CAPACITY) begin
        bad = $urandom_range(sets_issued, 255);
        if (req.func == OP_UNION && $urandom_range(0, 1)) begin
          req.elem_a = IDX_W'($urandom_range(0, sets_issued - 1));
          req.elem_b = IDX_W'(bad);
        end else begin
          req.elem_a = IDX_W'(bad);
        end
      end
    end else if (roll < 50) begin
      // Extend the chain: union(k-1, k) for k going down.
      if (chain_cursor == 0 || chain_cursor >= sets_issued)
        chain_cursor = sets_issued - 1;
      req.func   = OP_UNION;
      req.elem_a = IDX_W'(chain_cursor - 1);
      req.elem_b = IDX_W'(chain_cursor);
      chain_cursor--;
      if ($urandom_range(0, 1)) begin
        swap       = req.elem_a;
        req.elem_a = req.elem_b;
        req.elem_b = swap;
      end
    end else if (roll < 80) begin
      // Find, often from the top of the table where chains start.
      req.func   = OP_FIND;
      req.elem_a = $urandom_range(0, 2) == 0 ? IDX_W'(sets_issued - 1)
                                             : IDX_W'($urandom_range(0, sets_issued - 1));
    end else begin
      req.func   = OP_UNION;
      req.elem_a = IDX_W'($urandom_range(0, sets_issued - 1));
      req.elem_b = IDX_W'($urandom_range(0, sets_issued - 1));
    end
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    dsu_in_t     directed [$];
    dsu_in_t     req;
    int unsigned accepted_items;
    int unsigned burst;
    int unsigned gap;
    bit          paused;

    sb = new();
    accepted_items = 0;
    paused = 1'b0;

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty table, a small chain, same-set union,
    // unallocated operands on each side, the unused selector and
    // extreme index values.
    directed = '{
      build(OP_FIND,   0,   0),
      build(OP_UNION,  0,   0),
      build(OP_UNUSED, 255, 255),
      build(OP_MAKE,   255, 255),
      build(OP_MAKE,   0,   0),
      build(OP_MAKE,   170, 85),
      build(OP_MAKE,   85,  170),
      build(OP_FIND,   0,   255),
      build(OP_FIND,   3,   0),
      build(OP_UNION,  3,   2),
      build(OP_UNION,  2,   1),
      build(OP_UNION,  1,   0),
      build(OP_FIND,   3,   0),
      build(OP_UNION,  3,   0),
      build(OP_UNION,  0,   4),
      build(OP_UNION,  4,   0),
      build(OP_FIND,   4,   0),
      build(OP_FIND,   255, 255),
      build(OP_UNION,  255, 255),
      build(OP_UNUSED, 0,   0)
    };
    foreach (directed[i]) send(directed[i]);

    // Random part: bursts of back-to-back requests with random gaps, some
    // bursts followed by no gap at all.
    while (accepted_items < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 48);
      repeat (burst) begin
        req = pick_request();
        send(req);
        accepted_items++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) idle(gap);
      // Once mid-run, hold off until the block has drained completely.
      if (!paused && accepted_items >= PAUSE_AT) begin
        paused = 1'b1;
        idle(1);
        while (sb.awaited_results.size() != 0) @(posedge clk);
      end
    end
    idle(1);

    // Drain, then give any stray result time to show up.
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.awaited_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived",
                                   sb.awaited_results.size()));

    $display("covered %0d new sets (%0d refused as full), %0d finds, %0d unions",
             sb.n_make, sb.n_full, sb.n_find, sb.n_union);
    $display("  %0d joined, %0d unused codes, %0d on unallocated elements",
             sb.n_joined, sb.n_unused, sb.n_unalloc);
    $display("longest walk %0d hops, %0d results checked, %0d mismatches",
             sb.deepest_walk, sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
src/dsu_pkg.sv
src/dsu_ram.sv
src/dsu_datapath.sv
src/dsu_ctrl.sv
src/disjoint_set_union_table.sv
tb/testbench.sv
